// ===== design/fvn_pkg.sv =====
// ----------------------------------------------------------------------------
// fvn_pkg: shared types and constants of the fractal value noise block
// Field widths, hash and smoothing constants, register indexes.
// ----------------------------------------------------------------------------
package fvn_pkg;

    // default parameter values
    localparam int MAX_OCTAVES_DEF = 8;
    localparam int COORD_FRAC_DEF  = 16;

    // field and datapath widths
    localparam int SEED_W  = 32;
    localparam int FREQ_W  = 24;
    localparam int CNT_W   = 4;
    localparam int ROUGH_W = 18;
    localparam int OUT_W   = 17;
    localparam int HASH_W  = 32;
    localparam int VAL_W   = 24;   // corner values, Q0.24
    localparam int WGT_W   = 20;   // smootherstep weights, Q0.16 with headroom
    localparam int FRAC_W  = 16;   // lattice fraction
    localparam int QUO_W   = 16;   // quotient bits of the final divide
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 4;
    localparam int LANE_LAT = 10;  // register stages inside one octave lane

    // lattice hash
    localparam logic [HASH_W-1:0] HASH_MUL_X   = 32'd374761393;
    localparam logic [HASH_W-1:0] HASH_MUL_Y   = 32'd668265263;
    localparam logic [HASH_W-1:0] HASH_MUL_MIX = 32'd1274126177;
    localparam int                OCT_SEED_STEP = 7919;

    // amplitude
    localparam logic [ROUGH_W-1:0] ROUGH_MAX = 18'd131072;
    localparam int                 AMP_ONE   = 65536;

    // register map, index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_BASE_SEED = 2'd0,
        REG_BASE_FREQ = 2'd1,
        REG_OCT_COUNT = 2'd2,
        REG_ROUGHNESS = 2'd3
    } t_reg_idx;

endpackage

// ===== design/fvn_octave.sv =====
// ----------------------------------------------------------------------------
// fvn_octave: one octave of value noise
// Lattice hash of four corners, smootherstep weights, bilinear blend and
// amplitude weighting, ten register stages under a shared advance enable.
// ----------------------------------------------------------------------------
module fvn_octave #(
    parameter int OCT             = 0,
    parameter int COORD_FRAC_BITS = fvn_pkg::COORD_FRAC_DEF,
    parameter int AMP_W           = 24
) (
    input  logic                                     i_clk,
    input  logic                                     i_en,
    input  logic [COORD_FRAC_BITS+fvn_pkg::FREQ_W:0] i_pu,
    input  logic [COORD_FRAC_BITS+fvn_pkg::FREQ_W:0] i_pv,
    input  logic [fvn_pkg::SEED_W-1:0]               i_base_seed,
    input  logic [AMP_W-1:0]                         i_amp,
    input  logic                                     i_on,
    output logic [fvn_pkg::VAL_W+AMP_W-1:0]          o_wval
);

    localparam int XW = COORD_FRAC_BITS + fvn_pkg::FRAC_W + fvn_pkg::HASH_W;
    localparam int HW = fvn_pkg::HASH_W;
    localparam int VW = fvn_pkg::VAL_W;
    localparam int WW = fvn_pkg::WGT_W;
    localparam int FW = fvn_pkg::FRAC_W;
    localparam int PRW = VW + WW;
    localparam logic [HW-1:0] SEED_OFS = HW'(OCT * fvn_pkg::OCT_SEED_STEP);
    localparam logic [WW-1:0] K15 = WW'(15 * 65536);
    localparam logic [WW-1:0] K10 = WW'(10 * 65536);
    localparam logic [WW-1:0] K6  = WW'(6);

    // stage 1: lattice index products, smoothing first terms
    logic [XW-1:0]   w_px  [2];
    logic [HW-1:0]   w_lat [2];
    logic [FW-1:0]   w_t   [2];
    logic [WW-1:0]   w_m   [2];
    logic [FW+WW-1:0] w_pm [2];
    logic [2*FW-1:0] w_tt  [2];
    logic [HW-1:0]   r1_hm [2];
    logic [FW-1:0]   r1_t  [2];
    logic [WW-1:0]   r1_p  [2];
    logic [FW-1:0]   r1_t2 [2];

    always_comb begin
        w_px[0] = XW'(i_pu) << OCT;
        w_px[1] = XW'(i_pv) << OCT;
        for (int a = 0; a < 2; a++) begin
            w_lat[a] = w_px[a][COORD_FRAC_BITS+FW +: HW];
            w_t[a]   = w_px[a][COORD_FRAC_BITS +: FW];
            w_m[a]   = K15 - (WW'(w_t[a]) * K6);
            w_pm[a]  = (FW+WW)'(w_t[a]) * (FW+WW)'(w_m[a]);
            w_tt[a]  = (2*FW)'(w_t[a]) * (2*FW)'(w_t[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_hm[0] <= w_lat[0] * fvn_pkg::HASH_MUL_X;
            r1_hm[1] <= w_lat[1] * fvn_pkg::HASH_MUL_Y;
            for (int a = 0; a < 2; a++) begin
                r1_t[a]  <= w_t[a];
                r1_p[a]  <= w_pm[a][FW+WW-1:FW];
                r1_t2[a] <= w_tt[a][2*FW-1:FW];
            end
        end
    end

    // stage 2: seed add and first mix of the four corners
    logic [HW-1:0]   w_seed;
    logic [HW-1:0]   w_hx  [2];
    logic [HW-1:0]   w_hy  [2];
    logic [HW-1:0]   w_h   [4];
    logic [2*FW-1:0] w_t3p [2];
    logic [HW-1:0]   r2_pre [4];
    logic [WW-1:0]   r2_q  [2];
    logic [FW-1:0]   r2_t3 [2];

    always_comb begin
        w_seed = i_base_seed + SEED_OFS;
        w_hx[0] = r1_hm[0];
        w_hx[1] = r1_hm[0] + fvn_pkg::HASH_MUL_X;
        w_hy[0] = r1_hm[1];
        w_hy[1] = r1_hm[1] + fvn_pkg::HASH_MUL_Y;
        for (int c = 0; c < 4; c++) begin
            w_h[c] = w_seed + w_hx[c % 2] + w_hy[c / 2];
        end
        for (int a = 0; a < 2; a++) begin
            w_t3p[a] = (2*FW)'(r1_t2[a]) * (2*FW)'(r1_t[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 4; c++) begin
                r2_pre[c] <= w_h[c] ^ (w_h[c] >> 13);
            end
            for (int a = 0; a < 2; a++) begin
                r2_q[a]  <= K10 - r1_p[a];
                r2_t3[a] <= w_t3p[a][2*FW-1:FW];
            end
        end
    end

    // stage 3: final hash multiply, smootherstep weight
    logic [FW+WW-1:0] w_sp [2];
    logic [HW-1:0]    r3_hm [4];
    logic [WW-1:0]    r3_w  [2];

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            w_sp[a] = (FW+WW)'(r2_t3[a]) * (FW+WW)'(r2_q[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 4; c++) begin
                r3_hm[c] <= r2_pre[c] * fvn_pkg::HASH_MUL_MIX;
            end
            for (int a = 0; a < 2; a++) begin
                r3_w[a] <= w_sp[a][FW+WW-1:FW];
            end
        end
    end

    // stage 4: corner values, horizontal blend setup (row 0 = top, row 1 = bottom)
    logic [HW-1:0] w_hf [4];
    logic [VW-1:0] w_cv [4];
    logic [VW-1:0] r4_a   [2];
    logic [VW-1:0] r4_d   [2];
    logic          r4_neg [2];
    logic [WW-1:0] r4_w   [2];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_hf[c] = r3_hm[c] ^ (r3_hm[c] >> 16);
            w_cv[c] = w_hf[c][VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 2; r++) begin
                r4_a[r]   <= w_cv[2*r];
                r4_neg[r] <= w_cv[2*r+1] < w_cv[2*r];
                r4_d[r]   <= (w_cv[2*r+1] < w_cv[2*r]) ? w_cv[2*r] - w_cv[2*r+1]
                                                       : w_cv[2*r+1] - w_cv[2*r];
            end
            r4_w <= r3_w;
        end
    end

    // stage 5: horizontal weight products
    logic [PRW-1:0] w_hp [2];
    logic [VW-1:0]  r5_sh  [2];
    logic [VW-1:0]  r5_a   [2];
    logic           r5_neg [2];
    logic [WW-1:0]  r5_wy;

    always_comb begin
        for (int r = 0; r < 2; r++) begin
            w_hp[r] = PRW'(r4_d[r]) * PRW'(r4_w[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 2; r++) begin
                r5_sh[r] <= w_hp[r][FW +: VW];
            end
            r5_a   <= r4_a;
            r5_neg <= r4_neg;
            r5_wy  <= r4_w[1];
        end
    end

    // stage 6: row values
    logic [VW-1:0] r6_row [2];
    logic [WW-1:0] r6_wy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 2; r++) begin
                r6_row[r] <= r5_neg[r] ? r5_a[r] - r5_sh[r] : r5_a[r] + r5_sh[r];
            end
            r6_wy <= r5_wy;
        end
    end

    // stage 7: vertical blend setup
    logic [VW-1:0] r7_a;
    logic [VW-1:0] r7_d;
    logic          r7_neg;
    logic [WW-1:0] r7_wy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_a   <= r6_row[0];
            r7_neg <= r6_row[1] < r6_row[0];
            r7_d   <= (r6_row[1] < r6_row[0]) ? r6_row[0] - r6_row[1]
                                              : r6_row[1] - r6_row[0];
            r7_wy  <= r6_wy;
        end
    end

    // stage 8: vertical weight product
    logic [PRW-1:0] w_vp;
    logic [VW-1:0]  r8_sh;
    logic [VW-1:0]  r8_a;
    logic           r8_neg;

    assign w_vp = PRW'(r7_d) * PRW'(r7_wy);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r8_sh  <= w_vp[FW +: VW];
            r8_a   <= r7_a;
            r8_neg <= r7_neg;
        end
    end

    // stage 9: octave value
    logic [VW-1:0] r9_val;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r9_val <= r8_neg ? r8_a - r8_sh : r8_a + r8_sh;
        end
    end

    // stage 10: amplitude weighting, drop disabled octaves
    logic [VW+AMP_W-1:0] r_wval;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wval <= i_on ? (VW+AMP_W)'(r9_val) * (VW+AMP_W)'(i_amp) : '0;
        end
    end

    assign o_wval = r_wval;

endmodule

// ===== design/fractal_value_noise_top.sv =====
// ----------------------------------------------------------------------------
// fractal_value_noise_top: multi-octave 2-D value noise, smootherstep blend
// Octave lanes in parallel, a registered adder tree and a bit-per-stage divider.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the skid entry is empty and the amplitude table
// is not being rebuilt; set by the fully pipelined octave lanes and divider.
// A two-entry output stage (register plus skid) keeps intake open while one result waits.
// Reset: synchronous, active low; registers return to their defaults and the amplitude
// table is rebuilt, holding o_in_ready low while it runs, as it also does after every
// write to octave_count or roughness.
module fractal_value_noise_top #(
    parameter int MAX_OCTAVES     = fvn_pkg::MAX_OCTAVES_DEF,
    parameter int COORD_FRAC_BITS = fvn_pkg::COORD_FRAC_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // sample intake
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [COORD_FRAC_BITS:0]     i_coord_u,
    input  logic [COORD_FRAC_BITS:0]     i_coord_v,
    // result delivery
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [fvn_pkg::OUT_W-1:0]    o_noise_value,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fvn_pkg::ADDR_W-1:0]   paddr,
    input  logic [fvn_pkg::DATA_W-1:0]   pwdata,
    output logic [fvn_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    localparam int CW   = COORD_FRAC_BITS + 1;
    localparam int PW   = CW + fvn_pkg::FREQ_W;
    localparam int AW   = 16 + MAX_OCTAVES;          // largest amplitude is 2^(15+MAX)
    localparam int NW   = AW + 1;                     // sum of amplitudes
    localparam int WVW  = fvn_pkg::VAL_W + AW;
    localparam int LVL  = $clog2(MAX_OCTAVES);
    localparam int NP   = 1 << LVL;
    localparam int SW   = WVW + LVL;
    localparam int QB   = fvn_pkg::QUO_W;
    localparam int DW   = NW + 8;
    localparam int RW   = DW + QB;                    // total < norm * 2^24 fits here
    localparam int IW   = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
    localparam int CNW  = $clog2(MAX_OCTAVES + 1);
    localparam int NSTG = 1 + fvn_pkg::LANE_LAT + LVL + QB;
    localparam int RGW  = fvn_pkg::ROUGH_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [fvn_pkg::SEED_W-1:0]  r_seed;
    logic [fvn_pkg::FREQ_W-1:0]  r_freq;
    logic [fvn_pkg::CNT_W-1:0]   r_cnt;
    logic [RGW-1:0]              r_rough;
    fvn_pkg::t_reg_idx           w_idx;
    logic                        w_cfg_wr;
    logic                        w_retrig;

    assign w_idx    = fvn_pkg::t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr = psel && penable && pwrite;
    assign pready   = 1'b1;
    // amplitudes and their sum depend on count and roughness; rebuild on either
    assign w_retrig = w_cfg_wr && (w_idx == fvn_pkg::REG_OCT_COUNT ||
                                   w_idx == fvn_pkg::REG_ROUGHNESS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed  <= '0;
            r_freq  <= fvn_pkg::FREQ_W'(65536);
            r_cnt   <= fvn_pkg::CNT_W'(4);
            r_rough <= RGW'(32768);
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                fvn_pkg::REG_BASE_SEED: r_seed  <= pwdata[fvn_pkg::SEED_W-1:0];
                fvn_pkg::REG_BASE_FREQ: r_freq  <= pwdata[fvn_pkg::FREQ_W-1:0];
                fvn_pkg::REG_OCT_COUNT: r_cnt   <= pwdata[fvn_pkg::CNT_W-1:0];
                fvn_pkg::REG_ROUGHNESS: r_rough <= pwdata[RGW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            fvn_pkg::REG_BASE_SEED: prdata = fvn_pkg::DATA_W'(r_seed);
            fvn_pkg::REG_BASE_FREQ: prdata = fvn_pkg::DATA_W'(r_freq);
            fvn_pkg::REG_OCT_COUNT: prdata = fvn_pkg::DATA_W'(r_cnt);
            fvn_pkg::REG_ROUGHNESS: prdata = fvn_pkg::DATA_W'(r_rough);
            default:                prdata = '0;
        endcase
    end

    // effective octave count: zero acts as one, saturate at the lane count
    logic [CNW-1:0]          w_cnt_eff;
    logic [RGW-1:0]          w_rough_sat;
    logic [MAX_OCTAVES-1:0]  w_lane_on;

    always_comb begin
        if (r_cnt == '0) begin
            w_cnt_eff = CNW'(1);
        end else if (int'(r_cnt) > MAX_OCTAVES) begin
            w_cnt_eff = CNW'(MAX_OCTAVES);
        end else begin
            w_cnt_eff = CNW'(r_cnt);
        end
        w_rough_sat = (r_rough > fvn_pkg::ROUGH_MAX) ? fvn_pkg::ROUGH_MAX : r_rough;
        for (int o = 0; o < MAX_OCTAVES; o++) begin
            w_lane_on[o] = w_cnt_eff > CNW'(o);
        end
    end

    // ------------------------------------------------------------------
    // Amplitude table: one octave per cycle, amp(k+1) = amp(k)*rough >> 16,
    // norm sums the enabled octaves. Hold intake while it runs.
    // ------------------------------------------------------------------
    logic [AW-1:0]        r_amp [MAX_OCTAVES];
    logic [AW-1:0]        r_amp_cur;
    logic [NW-1:0]        r_norm;
    logic [IW-1:0]        r_amp_i;
    logic                 r_busy;
    logic [AW+RGW-1:0]    w_amp_prod;

    assign w_amp_prod = (AW+RGW)'(r_amp_cur) * (AW+RGW)'(w_rough_sat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_retrig) begin
            r_busy    <= 1'b1;
            r_amp_i   <= '0;
            r_amp_cur <= AW'(fvn_pkg::AMP_ONE);
            r_norm    <= '0;
        end else if (r_busy) begin
            r_amp_cur <= w_amp_prod[16 +: AW];
            if (w_cnt_eff > CNW'(r_amp_i)) begin
                r_norm <= r_norm + NW'(r_amp_cur);
            end
            if (r_amp_i == IW'(MAX_OCTAVES - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_amp_i <= r_amp_i + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_amp[r_amp_i] <= r_amp_cur;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances together unless the skid
    // entry is occupied; valid bits travel with the data.
    // ------------------------------------------------------------------
    logic              w_en;
    logic              w_in_fire;
    logic [NSTG-1:0]   r_vld;
    logic              r_out_vld;
    logic              r_sk_vld;
    logic [fvn_pkg::OUT_W-1:0] r_out_val;
    logic [fvn_pkg::OUT_W-1:0] r_sk_val;
    logic              w_take;

    assign w_en       = !r_sk_vld;
    assign o_in_ready = w_en && !r_busy;
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_take     = r_out_vld && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], w_in_fire};
        end
    end

    // stage 0: scale the coordinate by the base frequency
    logic [PW-1:0] r_pu;
    logic [PW-1:0] r_pv;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pu <= PW'(i_coord_u) * PW'(r_freq);
            r_pv <= PW'(i_coord_v) * PW'(r_freq);
        end
    end

    // ------------------------------------------------------------------
    // Octave lanes, one per octave; the lane shifts by its own octave
    // ------------------------------------------------------------------
    logic [WVW-1:0] w_wval [MAX_OCTAVES];

    for (genvar go = 0; go < MAX_OCTAVES; go++) begin : g_lane
        fvn_octave #(
            .OCT             (go),
            .COORD_FRAC_BITS (COORD_FRAC_BITS),
            .AMP_W           (AW)
        ) u_octave (
            .i_clk       (i_clk),
            .i_en        (w_en),
            .i_pu        (r_pu),
            .i_pv        (r_pv),
            .i_base_seed (r_seed),
            .i_amp       (r_amp[go]),
            .i_on        (w_lane_on[go]),
            .o_wval      (w_wval[go])
        );
    end

    // ------------------------------------------------------------------
    // Registered adder tree, heap order: node n sums nodes 2n+1 and 2n+2
    // ------------------------------------------------------------------
    logic [SW-1:0] w_leaf [NP];
    logic [SW-1:0] w_total;

    for (genvar gl = 0; gl < NP; gl++) begin : g_leaf
        if (gl < MAX_OCTAVES) begin : g_used
            assign w_leaf[gl] = SW'(w_wval[gl]);
        end else begin : g_pad
            assign w_leaf[gl] = '0;
        end
    end

    if (LVL == 0) begin : g_no_tree
        assign w_total = w_leaf[0];
    end else begin : g_tree
        logic [SW-1:0] r_node [NP-1];
        logic [SW-1:0] w_all  [2*NP-1];

        for (genvar gn = 0; gn < 2*NP-1; gn++) begin : g_all
            if (gn < NP-1) begin : g_inner
                assign w_all[gn] = r_node[gn];
            end else begin : g_outer
                assign w_all[gn] = w_leaf[gn-(NP-1)];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                for (int n = 0; n < NP-1; n++) begin
                    r_node[n] <= w_all[2*n+1] + w_all[2*n+2];
                end
            end
        end

        assign w_total = r_node[0];
    end

    // ------------------------------------------------------------------
    // Divide total by norm*2^8, one quotient bit per stage, MSB first
    // ------------------------------------------------------------------
    logic [DW-1:0] w_den;
    logic [RW-1:0] r_rem [QB-1];
    logic [QB-1:0] r_quo [QB];

    assign w_den = {r_norm, 8'd0};

    for (genvar gi = 0; gi < QB; gi++) begin : g_div
        logic [RW-1:0] w_num;
        logic [RW-1:0] w_sub;
        logic [QB-1:0] w_qin;
        logic          w_ge;

        if (gi == 0) begin : g_first
            assign w_num = RW'(w_total);
            assign w_qin = '0;
        end else begin : g_next
            assign w_num = r_rem[gi-1];
            assign w_qin = r_quo[gi-1];
        end

        assign w_sub = RW'(w_den) << (QB-1-gi);
        assign w_ge  = w_num >= w_sub;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_quo[gi] <= w_ge ? (w_qin | (QB'(1) << (QB-1-gi))) : w_qin;
            end
        end

        if (gi < QB-1) begin : g_keep_rem
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_rem[gi] <= w_ge ? w_num - w_sub : w_num;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid entry
    // ------------------------------------------------------------------
    logic [fvn_pkg::OUT_W-1:0] w_res;

    // a zero amplitude sum yields zero
    assign w_res = (r_norm == '0) ? '0 : fvn_pkg::OUT_W'(r_quo[QB-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_sk_vld  <= 1'b0;
        end else if (r_sk_vld) begin
            // pipeline holds; drain the skid entry once the output frees up
            if (w_take) begin
                r_out_vld <= 1'b1;
                r_sk_vld  <= 1'b0;
            end
        end else if (!r_out_vld || w_take) begin
            r_out_vld <= r_vld[NSTG-1];
        end else if (r_vld[NSTG-1]) begin
            r_sk_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_vld) begin
            if (w_take) begin
                r_out_val <= r_sk_val;
            end
        end else if (!r_out_vld || w_take) begin
            r_out_val <= w_res;
        end else if (r_vld[NSTG-1]) begin
            r_sk_val <= w_res;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_noise_value = r_out_val;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_vld |-> r_out_vld)
        else $error("skid entry occupied while output register is empty");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-1] && !r_sk_vld && r_out_vld && !i_out_ready) |=> r_sk_vld)
        else $error("finished item not captured while output stalled");

    a_refresh_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !w_retrig && r_amp_i == IW'(MAX_OCTAVES - 1)) |=> !r_busy)
        else $error("amplitude refresh did not finish");

    a_norm_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_norm != '0))
        else $error("amplitude sum is zero after refresh");

endmodule

// ===== verif/tb_fractal_value_noise_top.sv =====
// ----------------------------------------------------------------------------
// tb_fractal_value_noise_top: self-checking bench for the fractal noise block
// Drives directed and random coordinates through several register settings and
// idle patterns, predicts every noise value and compares it on delivery.
// ----------------------------------------------------------------------------
module tb_fractal_value_noise_top;

    localparam int CF       = fvn_pkg::COORD_FRAC_DEF;
    localparam int NOCT     = fvn_pkg::MAX_OCTAVES_DEF;
    localparam int OW       = fvn_pkg::OUT_W;
    localparam int DRAIN    = 60;     // beyond the pipeline latency
    localparam int N_RANDOM = 1200;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic [CF:0]                i_coord_u = '0;
    logic [CF:0]                i_coord_v = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [OW-1:0]              o_noise_value;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [fvn_pkg::ADDR_W-1:0] paddr = '0;
    logic [fvn_pkg::DATA_W-1:0] pwdata = '0;
    logic [fvn_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    fractal_value_noise_top dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor copy of the registers
    logic [fvn_pkg::SEED_W-1:0]  seed_q = '0;
    logic [fvn_pkg::FREQ_W-1:0]  freq_q = 24'd65536;
    logic [fvn_pkg::CNT_W-1:0]   count_q = 4'd4;
    logic [fvn_pkg::ROUGH_W-1:0] rough_q = 18'd32768;

    logic [OW-1:0] noise_q[$];
    int  errors = 0;
    int  send_idle = 0;     // percent of cycles the sender holds back
    int  recv_stall = 0;    // percent of cycles the receiver stalls

    function automatic logic [31:0] lattice_mix(logic [31:0] x, logic [31:0] y,
                                                logic [31:0] s);
        logic [31:0] h;
        h = s + x * fvn_pkg::HASH_MUL_X + y * fvn_pkg::HASH_MUL_Y;
        h = (h ^ (h >> 13)) * fvn_pkg::HASH_MUL_MIX;
        return h ^ (h >> 16);
    endfunction

    function automatic logic [63:0] fade(logic [63:0] t);
        logic [63:0] p, q, t2, t3;
        p  = (t * (64'd15 * 65536 - 64'd6 * t)) >> 16;
        q  = 64'd10 * 65536 - p;
        t2 = (t * t) >> 16;
        t3 = (t2 * t) >> 16;
        return (t3 * q) >> 16;
    endfunction

    function automatic logic [63:0] mix(logic [63:0] a, logic [63:0] b, logic [63:0] w);
        if (b >= a) return a + (((b - a) * w) >> 16);
        return a - (((a - b) * w) >> 16);
    endfunction

    function automatic logic [OW-1:0] noise_at(logic [CF:0] u, logic [CF:0] v);
        logic [63:0] px, py, fx, fy, top, bot, val, amp, total, norm, rough;
        logic [31:0] xi, yi, s;
        int cnt;
        cnt   = (count_q == 0) ? 1 : (count_q > NOCT ? NOCT : int'(count_q));
        rough = (rough_q > fvn_pkg::ROUGH_MAX) ? 64'(fvn_pkg::ROUGH_MAX) : 64'(rough_q);
        amp = 64'd65536; total = '0; norm = '0;
        for (int o = 0; o < cnt; o++) begin
            px = (64'(u) * 64'(freq_q)) << o;
            py = (64'(v) * 64'(freq_q)) << o;
            xi = px[CF+16 +: 32];
            yi = py[CF+16 +: 32];
            fx = fade((px >> CF) & 64'hFFFF);
            fy = fade((py >> CF) & 64'hFFFF);
            s  = seed_q + 32'(o) * 32'(fvn_pkg::OCT_SEED_STEP);
            top = mix(lattice_mix(xi, yi, s) & 32'hFFFFFF,
                      lattice_mix(xi + 1, yi, s) & 32'hFFFFFF, fx);
            bot = mix(lattice_mix(xi, yi + 1, s) & 32'hFFFFFF,
                      lattice_mix(xi + 1, yi + 1, s) & 32'hFFFFFF, fx);
            val = mix(top, bot, fy);
            total += val * amp;
            norm  += amp;
            amp = (amp * rough) >> 16;
        end
        if (norm == 0) return '0;
        return OW'(total / (norm << 8));
    endfunction

    // write one register over the APB port, keeping the predictor in step
    task automatic reg_write(fvn_pkg::t_reg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            fvn_pkg::REG_BASE_SEED: seed_q  = val;
            fvn_pkg::REG_BASE_FREQ: freq_q  = val[fvn_pkg::FREQ_W-1:0];
            fvn_pkg::REG_OCT_COUNT: count_q = val[fvn_pkg::CNT_W-1:0];
            fvn_pkg::REG_ROUGHNESS: rough_q = val[fvn_pkg::ROUGH_W-1:0];
            default: ;
        endcase
    endtask

    // offer one item, hold it until accepted; predict on acceptance
    task automatic send_item(logic [CF:0] u, logic [CF:0] v, logic has_gold,
                             logic [OW-1:0] gold);
        logic [OW-1:0] pred;
        while ($urandom_range(99) < send_idle) @(negedge i_clk);
        i_coord_u = u; i_coord_v = v; i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pred = noise_at(u, v);
        if (has_gold && gold != pred) begin
            $error("noise_value for (%0d,%0d): expected %0d actual %0d",
                   u, v, gold, pred);
            errors++;
        end
        noise_q = {noise_q, pred};
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // wait until every predicted result has come back, then let the pipe drain
    task automatic drain_all();
        while (noise_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    // receiver: stall at random, check each delivered item against the oldest prediction
    always @(negedge i_clk)
        if (i_rst_n) i_out_ready <= ($urandom_range(99) >= recv_stall);

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (noise_q.size() == 0) begin
                $error("noise_value %0d delivered with no item pending", o_noise_value);
                errors++;
            end else begin
                logic [OW-1:0] want;
                want = noise_q.pop_front();
                if (o_noise_value !== want) begin
                    $error("noise_value: expected %0d actual %0d", want, o_noise_value);
                    errors++;
                end
            end
        end
    end

    // directed table: coordinate extremes and assorted points; no entry carries a gold value
    typedef struct {
        logic [CF:0]   u;
        logic [CF:0]   v;
        logic          has_gold;
        logic [OW-1:0] gold;
    } t_probe;

    t_probe probes[10] = '{
        '{17'd0,     17'd0,     1'b0, '0},
        '{17'd65536, 17'd0,     1'b0, '0},
        '{17'd0,     17'd65536, 1'b0, '0},
        '{17'd65536, 17'd65536, 1'b0, '0},
        '{17'd131071,17'd131071,1'b0, '0},
        '{17'd32768, 17'd32768, 1'b0, '0},
        '{17'd1,     17'd65535, 1'b0, '0},
        '{17'd65535, 17'd1,     1'b0, '0},
        '{17'd21845, 17'd43690, 1'b0, '0},
        '{17'd100000,17'd77777, 1'b0, '0}
    };

    // send every probe under the current settings; the run walks defaults, extremes, saturating cases
    task automatic run_probes();
        foreach (probes[i]) send_item(probes[i].u, probes[i].v,
                                      probes[i].has_gold, probes[i].gold);
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++) begin
            logic [CF:0] u, v;
            u = ($urandom_range(9) == 0) ? CF'(0) | 17'($urandom_range(1) * 65536)
                : 17'($urandom_range(65536));
            v = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
            send_item(u, v, 1'b0, '0);
        end
    endtask

    task automatic random_config();
        reg_write(fvn_pkg::REG_BASE_SEED, $urandom);
        reg_write(fvn_pkg::REG_BASE_FREQ, ($urandom_range(3) == 0) ? $urandom & 32'hFFFFFF
                                                                   : $urandom_range(1 << 20));
        reg_write(fvn_pkg::REG_OCT_COUNT, $urandom_range(15));
        reg_write(fvn_pkg::REG_ROUGHNESS, $urandom & 32'h3FFFF);
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // defaults after reset: the table settles before intake opens
        run_probes();
        drain_all();

        // extremes: zero octaves, zero frequency, zero roughness
        reg_write(fvn_pkg::REG_OCT_COUNT, 0);
        reg_write(fvn_pkg::REG_BASE_FREQ, 0);
        reg_write(fvn_pkg::REG_ROUGHNESS, 0);
        reg_write(fvn_pkg::REG_BASE_SEED, 32'hFFFFFFFF);
        run_probes();
        drain_all();

        // saturation: too many octaves, excess roughness, top frequency
        reg_write(fvn_pkg::REG_OCT_COUNT, 15);
        reg_write(fvn_pkg::REG_BASE_FREQ, 24'hFFFFFF);
        reg_write(fvn_pkg::REG_ROUGHNESS, 18'h3FFFF);
        run_probes();
        drain_all();

        // random phases with rotating idle patterns
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 86; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 86; end
                default: begin send_idle = 36; recv_stall = 36; end
            endcase
            random_config();
            run_random(N_RANDOM / 8);
            drain_all();
        end

        send_idle = 0; recv_stall = 0;
        drain_all();
        if (errors == 0 && noise_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #20000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
design/fvn_pkg.sv
design/fvn_octave.sv
design/fractal_value_noise_top.sv
verif/tb_fractal_value_noise_top.sv
